/* design/line_segment_clipper_top_assert.svh */
`ifndef LINE_SEGMENT_CLIPPER_TOP_ASSERT_SVH
`define LINE_SEGMENT_CLIPPER_TOP_ASSERT_SVH
// Checked while out of reset.
`define LSCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define LSCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* design/lscl_pkg.sv */
package lscl_pkg;

  typedef struct packed {
    logic valid;
    logic done;
    logic acc;
  } ctl_t;

  typedef struct packed {
    logic [3:0] c0;
    logic [3:0] c1;
  } codes_t;

  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_TOP    = 4'd8;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_BOTTOM = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

endpackage

/* design/lscl_pass.sv */
module lscl_pass #(
  parameter int W = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [W-1:0]         win_left,
  input  logic [W-1:0]         win_right,
  input  logic [W-1:0]         win_bottom,
  input  logic [W-1:0]         win_top,
  input  lscl_pkg::ctl_t       in_ctl,
  input  logic [W-1:0]         in_x0,
  input  logic [W-1:0]         in_y0,
  input  logic [W-1:0]         in_x1,
  input  logic [W-1:0]         in_y1,
  output lscl_pkg::ctl_t       out_ctl,
  output logic [W-1:0]         out_x0,
  output logic [W-1:0]         out_y0,
  output logic [W-1:0]         out_x1,
  output logic [W-1:0]         out_y1,
  output lscl_pkg::codes_t     out_codes
);

  localparam int NDS = (W + 1) / 2;
  localparam int NSB = NDS + 2;
  localparam int L   = NSB - 1;

  function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
                                         input logic signed [W-1:0] y,
                                         input logic signed [W-1:0] wl,
                                         input logic signed [W-1:0] wr,
                                         input logic signed [W-1:0] wb,
                                         input logic signed [W-1:0] wt);
    logic [3:0] c;
    c = '0;
    if (x < wl) c = c | lscl_pkg::OC_LEFT;
    else if (x > wr) c = c | lscl_pkg::OC_RIGHT;
    if (y < wb) c = c | lscl_pkg::OC_BOTTOM;
    else if (y > wt) c = c | lscl_pkg::OC_TOP;
    return c;
  endfunction

  // stage A: decide, pick edge, form magnitudes
  logic [3:0]   a_c0, a_c1, a_co;
  logic         a_done, a_acc, a_sel_end, a_on_x, a_neg;
  logic [W-1:0] a_edge, a_base;
  logic [W:0]   a_n, a_m, a_d, a_na, a_ma, a_da;

  always_comb begin
    a_c0 = outcode(in_x0, in_y0, win_left, win_right, win_bottom, win_top);
    a_c1 = outcode(in_x1, in_y1, win_left, win_right, win_bottom, win_top);
    a_done = in_ctl.done;
    a_acc  = in_ctl.acc;
    if (!in_ctl.done) begin
      if ((a_c0 | a_c1) == 4'd0) begin
        a_done = 1'b1;
        a_acc  = 1'b1;
      end else if ((a_c0 & a_c1) != 4'd0) begin
        a_done = 1'b1;
        a_acc  = 1'b0;
      end
    end
    a_sel_end = (a_c0 == 4'd0);
    a_co = a_sel_end ? a_c1 : a_c0;
    if ((a_co & lscl_pkg::OC_TOP) != 4'd0) begin
      a_edge = win_top;
      a_on_x = 1'b0;
    end else if ((a_co & lscl_pkg::OC_BOTTOM) != 4'd0) begin
      a_edge = win_bottom;
      a_on_x = 1'b0;
    end else if ((a_co & lscl_pkg::OC_RIGHT) != 4'd0) begin
      a_edge = win_right;
      a_on_x = 1'b1;
    end else begin
      a_edge = win_left;
      a_on_x = 1'b1;
    end
    if (!a_on_x) begin
      a_n = {in_x1[W-1], in_x1} - {in_x0[W-1], in_x0};
      a_m = {a_edge[W-1], a_edge} - {in_y0[W-1], in_y0};
      a_d = {in_y1[W-1], in_y1} - {in_y0[W-1], in_y0};
      a_base = in_x0;
    end else begin
      a_n = {in_y1[W-1], in_y1} - {in_y0[W-1], in_y0};
      a_m = {a_edge[W-1], a_edge} - {in_x0[W-1], in_x0};
      a_d = {in_x1[W-1], in_x1} - {in_x0[W-1], in_x0};
      a_base = in_y0;
    end
    a_neg = a_n[W] ^ a_m[W] ^ a_d[W];
    a_na = a_n[W] ? (~a_n + 1'b1) : a_n;
    a_ma = a_m[W] ? (~a_m + 1'b1) : a_m;
    a_da = a_d[W] ? (~a_d + 1'b1) : a_d;
  end

  lscl_pkg::ctl_t ctl_r [NSB];
  logic [W-1:0] x0_r [NSB];
  logic [W-1:0] y0_r [NSB];
  logic [W-1:0] x1_r [NSB];
  logic [W-1:0] y1_r [NSB];
  logic [W-1:0] edge_r [NSB];
  logic [W-1:0] base_r [NSB];
  logic [W-1:0] ad_r [NSB];
  logic         neg_r [NSB];
  logic         on_x_r [NSB];
  logic         sel_end_r [NSB];
  logic [W-1:0] an_r, am_r;
  logic [W-1:0] rem_r [NDS+1];
  logic [W-1:0] quo_r [NDS+1];
  logic [W-1:0] lo_r [NDS+1];
  logic [2*W-1:0] prod;

  assign prod = an_r * am_r;

  // restoring division, two quotient bits per stage
  logic [W-1:0] dv_rem [NDS+1];
  logic [W-1:0] dv_quo [NDS+1];
  logic [W-1:0] dv_lo [NDS+1];

  always_comb begin
    logic [W:0]   t;
    logic [W-1:0] r, q, l;
    dv_rem[0] = prod[2*W-1:W];
    dv_lo[0]  = prod[W-1:0];
    dv_quo[0] = '0;
    for (int i = 1; i <= NDS; i++) begin
      r = rem_r[i-1];
      q = quo_r[i-1];
      l = lo_r[i-1];
      for (int j = 0; j < 2; j++) begin
        if ((i - 1) * 2 + j < W) begin
          t = {r, l[W-1]};
          l = {l[W-2:0], 1'b0};
          if (t >= {1'b0, ad_r[i]}) begin
            t = t - {1'b0, ad_r[i]};
            q = {q[W-2:0], 1'b1};
          end else begin
            q = {q[W-2:0], 1'b0};
          end
          r = t[W-1:0];
        end
      end
      dv_rem[i] = r;
      dv_quo[i] = q;
      dv_lo[i]  = l;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSB; i++) ctl_r[i] <= '0;
    end else if (en) begin
      ctl_r[0] <= '{valid: in_ctl.valid, done: a_done, acc: a_acc};
      for (int i = 1; i < NSB; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r[0] <= in_x0;
      y0_r[0] <= in_y0;
      x1_r[0] <= in_x1;
      y1_r[0] <= in_y1;
      edge_r[0] <= a_edge;
      base_r[0] <= a_base;
      ad_r[0] <= a_da[W-1:0];
      neg_r[0] <= a_neg;
      on_x_r[0] <= a_on_x;
      sel_end_r[0] <= a_sel_end;
      an_r <= a_na[W-1:0];
      am_r <= a_ma[W-1:0];
      for (int i = 1; i < NSB; i++) begin
        x0_r[i] <= x0_r[i-1];
        y0_r[i] <= y0_r[i-1];
        x1_r[i] <= x1_r[i-1];
        y1_r[i] <= y1_r[i-1];
        edge_r[i] <= edge_r[i-1];
        base_r[i] <= base_r[i-1];
        ad_r[i] <= ad_r[i-1];
        neg_r[i] <= neg_r[i-1];
        on_x_r[i] <= on_x_r[i-1];
        sel_end_r[i] <= sel_end_r[i-1];
      end
      for (int i = 0; i <= NDS; i++) begin
        rem_r[i] <= dv_rem[i];
        quo_r[i] <= dv_quo[i];
        lo_r[i]  <= dv_lo[i];
      end
    end
  end

  // final stage: new endpoint and its outcode
  logic [W:0]   f_qs, f_nc;
  logic [W-1:0] f_nx, f_ny, f_x0, f_y0, f_x1, f_y1;

  always_comb begin
    f_qs = neg_r[L] ? (~{1'b0, quo_r[NDS]} + 1'b1) : {1'b0, quo_r[NDS]};
    f_nc = {base_r[L][W-1], base_r[L]} + f_qs;
    f_nx = on_x_r[L] ? edge_r[L] : f_nc[W-1:0];
    f_ny = on_x_r[L] ? f_nc[W-1:0] : edge_r[L];
    f_x0 = x0_r[L];
    f_y0 = y0_r[L];
    f_x1 = x1_r[L];
    f_y1 = y1_r[L];
    if (!ctl_r[L].done) begin
      if (sel_end_r[L]) begin
        f_x1 = f_nx;
        f_y1 = f_ny;
      end else begin
        f_x0 = f_nx;
        f_y0 = f_ny;
      end
    end
  end

  lscl_pkg::ctl_t out_ctl_r;
  logic [W-1:0]   out_x0_r, out_y0_r, out_x1_r, out_y1_r;
  logic [3:0]     out_c0_r, out_c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl_r <= '0;
    end else if (en) begin
      out_ctl_r <= ctl_r[L];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x0_r <= f_x0;
      out_y0_r <= f_y0;
      out_x1_r <= f_x1;
      out_y1_r <= f_y1;
      out_c0_r <= outcode(f_x0, f_y0, win_left, win_right, win_bottom, win_top);
      out_c1_r <= outcode(f_x1, f_y1, win_left, win_right, win_bottom, win_top);
    end
  end

  assign out_ctl   = out_ctl_r;
  assign out_x0    = out_x0_r;
  assign out_y0    = out_y0_r;
  assign out_x1    = out_x1_r;
  assign out_y1    = out_y1_r;
  assign out_codes = '{c0: out_c0_r, c1: out_c1_r};

endmodule

/* design/line_segment_clipper_top.sv */
// Cohen-Sutherland segment clipper.
// Input channel (in_valid/in_ready): one segment per transaction, two
// endpoints as signed COORD_BITS coordinates.
// Output channel (out_valid/out_ready): accept flag plus clipped endpoints;
// a rejected segment returns all coordinates as zero.
// Config: APB-style, window left/right/bottom/top at byte offsets 0/4/8/12,
// written only while no transaction is in flight; the user must ensure it,
// as the block does not enforce it. pready is tied high. Throughput: one
// segment per cycle while out_ready does not stall the pipeline. Four clip
// passes are chained, each an edge-select stage, a multiply stage, a
// restoring divider retiring two quotient bits per stage, and a write-back
// stage. The whole pipeline advances together; when the receiver holds
// out_ready low with a result waiting, every stage and in_ready freeze,
// so nothing is dropped or repeated.
// Reset clears all pipeline valid bits and opens the window to the full
// coordinate range.
module line_segment_clipper_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_accepted,
  output logic [COORD_BITS-1:0] out_clipped_start_x,
  output logic [COORD_BITS-1:0] out_clipped_start_y,
  output logic [COORD_BITS-1:0] out_clipped_end_x,
  output logic [COORD_BITS-1:0] out_clipped_end_y,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int W = COORD_BITS;
  localparam int NPASS = 4;

  logic [W-1:0] win_left_r, win_right_r, win_bottom_r, win_top_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= {1'b1, {(W-1){1'b0}}};
      win_right_r  <= {1'b0, {(W-1){1'b1}}};
      win_bottom_r <= {1'b1, {(W-1){1'b0}}};
      win_top_r    <= {1'b0, {(W-1){1'b1}}};
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        lscl_pkg::REG_LEFT:   win_left_r   <= pwdata[W-1:0];
        lscl_pkg::REG_RIGHT:  win_right_r  <= pwdata[W-1:0];
        lscl_pkg::REG_BOTTOM: win_bottom_r <= pwdata[W-1:0];
        lscl_pkg::REG_TOP:    win_top_r    <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lscl_pkg::REG_LEFT:   prdata = 32'($signed(win_left_r));
      lscl_pkg::REG_RIGHT:  prdata = 32'($signed(win_right_r));
      lscl_pkg::REG_BOTTOM: prdata = 32'($signed(win_bottom_r));
      lscl_pkg::REG_TOP:    prdata = 32'($signed(win_top_r));
      default:              prdata = '0;
    endcase
  end

  logic out_valid_r, en;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  lscl_pkg::ctl_t   p_ctl [NPASS+1];
  logic [W-1:0]     p_x0 [NPASS+1];
  logic [W-1:0]     p_y0 [NPASS+1];
  logic [W-1:0]     p_x1 [NPASS+1];
  logic [W-1:0]     p_y1 [NPASS+1];
  lscl_pkg::codes_t p_codes [NPASS];

  assign p_ctl[0] = '{valid: in_valid, done: 1'b0, acc: 1'b0};
  assign p_x0[0]  = in_start_x;
  assign p_y0[0]  = in_start_y;
  assign p_x1[0]  = in_end_x;
  assign p_y1[0]  = in_end_y;

  for (genvar g = 0; g < NPASS; g++) begin : g_pass
    lscl_pass #(.W(W)) u_pass (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .win_left  (win_left_r),
      .win_right (win_right_r),
      .win_bottom(win_bottom_r),
      .win_top   (win_top_r),
      .in_ctl    (p_ctl[g]),
      .in_x0     (p_x0[g]),
      .in_y0     (p_y0[g]),
      .in_x1     (p_x1[g]),
      .in_y1     (p_y1[g]),
      .out_ctl   (p_ctl[g+1]),
      .out_x0    (p_x0[g+1]),
      .out_y0    (p_y0[g+1]),
      .out_x1    (p_x1[g+1]),
      .out_y1    (p_y1[g+1]),
      .out_codes (p_codes[g])
    );
  end

  // undecided after the last pass: accept only if both endpoints are inside
  logic f_acc;
  assign f_acc = p_ctl[NPASS].done ? p_ctl[NPASS].acc :
                 ((p_codes[NPASS-1].c0 | p_codes[NPASS-1].c1) == 4'd0);

  logic         out_acc_r;
  logic [W-1:0] out_sx_r, out_sy_r, out_ex_r, out_ey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p_ctl[NPASS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_acc_r <= f_acc;
      out_sx_r  <= f_acc ? p_x0[NPASS] : '0;
      out_sy_r  <= f_acc ? p_y0[NPASS] : '0;
      out_ex_r  <= f_acc ? p_x1[NPASS] : '0;
      out_ey_r  <= f_acc ? p_y1[NPASS] : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_acc_r;
  assign out_clipped_start_x = out_sx_r;
  assign out_clipped_start_y = out_sy_r;
  assign out_clipped_end_x   = out_ex_r;
  assign out_clipped_end_y   = out_ey_r;

endmodule

/* design/lscl_chk.sv */
`include "line_segment_clipper_top_assert.svh"

module lscl_chk #(
  parameter int W = 16
) (
  input logic         clk,
  input logic         rst_n,
  input logic         out_valid,
  input logic         out_ready,
  input logic         out_accepted,
  input logic [W-1:0] out_clipped_start_x,
  input logic [W-1:0] out_clipped_start_y,
  input logic [W-1:0] out_clipped_end_x,
  input logic [W-1:0] out_clipped_end_y,
  input logic         pready
);

  `LSCT_ASSERT_ALWAYS(a_no_valid_after_reset, !rst_n |=> !out_valid, "out_valid after reset")
  `LSCT_ASSERT(a_reject_zero, (out_valid && !out_accepted) |-> (out_clipped_start_x == '0 && out_clipped_start_y == '0 && out_clipped_end_x == '0 && out_clipped_end_y == '0), "rejected segment with nonzero coordinates")
  `LSCT_ASSERT(a_pready_high, pready, "pready dropped")
  `LSCT_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_accepted) && $stable(out_clipped_start_x) && $stable(out_clipped_end_y)), "result changed while stalled")

endmodule

bind line_segment_clipper_top lscl_chk #(.W(COORD_BITS)) u_lscl_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_accepted       (out_accepted),
  .out_clipped_start_x(out_clipped_start_x),
  .out_clipped_start_y(out_clipped_start_y),
  .out_clipped_end_x  (out_clipped_end_x),
  .out_clipped_end_y  (out_clipped_end_y),
  .pready             (pready)
);
